// File: rtl/core/drsp_pkg.sv
// drsp_pkg: shared types and constants of the dns response stream parser
// no dependencies; imported by every module of the block

package drsp_pkg;

    localparam int HEADER_BYTES = 12;
    localparam logic [3:0] HDR_LAST = 4'(HEADER_BYTES - 1);
    localparam logic [7:0] RCODE_MASK = 8'h0F;
    localparam logic [7:0] PTR_MASK = 8'hC0;

    localparam logic [15:0] TYPE_A = 16'd1;
    localparam logic [15:0] TYPE_CNAME = 16'd5;
    localparam logic [15:0] TYPE_AAAA = 16'd28;
    localparam logic [15:0] LEN_A = 16'd4;
    localparam logic [15:0] LEN_AAAA = 16'd16;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_Q_LEN,
        PH_Q_LABEL,
        PH_Q_PTR,
        PH_Q_TAIL,
        PH_A_LEN,
        PH_A_LABEL,
        PH_A_PTR,
        PH_A_FIXED,
        PH_A_ADDR,
        PH_A_SKIP,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        K_HEADER,
        K_RECORD,
        K_ADDR,
        K_SHORT,
        K_TRUNC,
        K_DONE
    } kind_t;

    typedef enum logic [1:0] {
        DK_NONE,
        DK_IPV4,
        DK_IPV6,
        DK_CNAME
    } dkind_t;

    typedef struct packed {
        kind_t        result_kind;
        logic [3:0]   resp_code;
        logic [15:0]  answer_total;
        logic [15:0]  record_kind;
        logic [31:0]  time_to_live;
        logic [15:0]  rdata_length;
        dkind_t       data_kind;
        logic [7:0]   address_byte;
        logic [3:0]   address_index;
        logic         final_result;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       res0;
        res_t       res1;
    } push_t;

endpackage

// File: rtl/core/drsp_parser_core.sv
// drsp_parser_core: parse state registers and the per-byte state update
// depends on drsp_pkg; produces up to two result words per accepted byte

module drsp_parser_core
    import drsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] byte_in,
    input  logic       eom,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  hp_reg, hp_next;
    logic [15:0] q_reg, q_next;
    logic [15:0] a_reg, a_next;
    logic [15:0] skip_reg, skip_next;
    logic [3:0]  fp_reg, fp_next;
    logic [15:0] kind_reg, kind_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [15:0] len_reg, len_next;
    logic [3:0]  code_reg, code_next;
    logic [4:0]  ap_reg, ap_next;

    res_t   first, fin;
    logic   first_v;
    dkind_t dk;
    logic   is_zero, is_ptr;
    logic [15:0] skip_dec, ans_dec;
    kind_t  end_kind;

    assign is_zero = (byte_in == 8'h00);
    assign is_ptr = ((byte_in & PTR_MASK) == PTR_MASK);
    assign skip_dec = skip_reg - 16'd1;
    assign ans_dec = a_reg - 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        hp_next = hp_reg;
        q_next = q_reg;
        a_next = a_reg;
        skip_next = skip_reg;
        fp_next = fp_reg;
        kind_next = kind_reg;
        ttl_next = ttl_reg;
        len_next = len_reg;
        code_next = code_reg;
        ap_next = ap_reg;
        first = '0;
        first_v = 1'b0;
        fin = '0;
        dk = DK_NONE;
        end_kind = K_DONE;

        case (phase_reg)
            PH_HEADER:
            begin
                case (hp_reg)
                    4'd3: code_next = 4'(byte_in & RCODE_MASK);
                    4'd4: q_next = {byte_in, 8'h00};
                    4'd5: q_next = {q_reg[15:8], byte_in};
                    4'd6: a_next = {byte_in, 8'h00};
                    4'd7:
                    begin
                        a_next = {a_reg[15:8], byte_in};
                        if (!eom)
                        begin
                            first_v = 1'b1;
                            first.result_kind = K_HEADER;
                            first.resp_code = code_reg;
                            first.answer_total = {a_reg[15:8], byte_in};
                        end
                    end
                    default: ;
                endcase
                if (hp_reg >= HDR_LAST)
                begin
                    if (q_reg != 16'd0)
                        phase_next = PH_Q_LEN;
                    else if (a_reg != 16'd0)
                        phase_next = PH_A_LEN;
                    else
                        phase_next = PH_TRAIL;
                end
                else
                    hp_next = hp_reg + 4'd1;
            end
            PH_Q_LEN:
            begin
                if (is_zero)
                begin
                    phase_next = PH_Q_TAIL;
                    fp_next = 4'd0;
                end
                else if (is_ptr)
                    phase_next = PH_Q_PTR;
                else
                begin
                    skip_next = {8'h00, byte_in};
                    phase_next = PH_Q_LABEL;
                end
            end
            PH_Q_LABEL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = PH_Q_LEN;
            end
            PH_Q_PTR:
            begin
                phase_next = PH_Q_TAIL;
                fp_next = 4'd0;
            end
            PH_Q_TAIL:
            begin
                if (fp_reg >= 4'd3)
                begin
                    q_next = q_reg - 16'd1;
                    if (q_reg - 16'd1 != 16'd0)
                        phase_next = PH_Q_LEN;
                    else if (a_reg != 16'd0)
                        phase_next = PH_A_LEN;
                    else
                        phase_next = PH_TRAIL;
                end
                else
                    fp_next = fp_reg + 4'd1;
            end
            PH_A_LEN:
            begin
                if (is_zero)
                begin
                    phase_next = PH_A_FIXED;
                    fp_next = 4'd0;
                end
                else if (is_ptr)
                    phase_next = PH_A_PTR;
                else
                begin
                    skip_next = {8'h00, byte_in};
                    phase_next = PH_A_LABEL;
                end
            end
            PH_A_LABEL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = PH_A_LEN;
            end
            PH_A_PTR:
            begin
                phase_next = PH_A_FIXED;
                fp_next = 4'd0;
            end
            PH_A_FIXED:
            begin
                case (fp_reg)
                    4'd0: kind_next = {byte_in, 8'h00};
                    4'd1: kind_next = {kind_reg[15:8], byte_in};
                    4'd4: ttl_next = {24'h000000, byte_in};
                    4'd5, 4'd6, 4'd7: ttl_next = {ttl_reg[23:0], byte_in};
                    4'd8: len_next = {byte_in, 8'h00};
                    4'd9: len_next = {len_reg[15:8], byte_in};
                    default: ;
                endcase
                if (fp_reg >= 4'd9)
                begin
                    if (kind_reg == TYPE_A && len_next == LEN_A)
                        dk = DK_IPV4;
                    else if (kind_reg == TYPE_AAAA && len_next == LEN_AAAA)
                        dk = DK_IPV6;
                    else if (kind_reg == TYPE_CNAME)
                        dk = DK_CNAME;
                    else
                        dk = DK_NONE;
                    first_v = 1'b1;
                    first.result_kind = K_RECORD;
                    first.record_kind = kind_reg;
                    first.time_to_live = ttl_reg;
                    first.rdata_length = len_next;
                    first.data_kind = dk;
                    if (dk == DK_IPV4 || dk == DK_IPV6)
                    begin
                        phase_next = PH_A_ADDR;
                        ap_next = 5'd0;
                    end
                    else if (len_next != 16'd0)
                    begin
                        phase_next = PH_A_SKIP;
                        skip_next = len_next;
                    end
                    else
                    begin
                        a_next = ans_dec;
                        phase_next = (ans_dec != 16'd0) ? PH_A_LEN : PH_TRAIL;
                    end
                end
                else
                    fp_next = fp_reg + 4'd1;
            end
            PH_A_ADDR:
            begin
                first_v = 1'b1;
                first.result_kind = K_ADDR;
                first.data_kind = (len_reg == LEN_A) ? DK_IPV4 : DK_IPV6;
                first.address_byte = byte_in;
                first.address_index = ap_reg[3:0];
                ap_next = ap_reg + 5'd1;
                if ({11'd0, ap_reg + 5'd1} >= len_reg)
                begin
                    a_next = ans_dec;
                    phase_next = (ans_dec != 16'd0) ? PH_A_LEN : PH_TRAIL;
                end
            end
            PH_A_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    a_next = ans_dec;
                    phase_next = (ans_dec != 16'd0) ? PH_A_LEN : PH_TRAIL;
                end
            end
            default: ;
        endcase

        if (phase_next == PH_HEADER)
            end_kind = K_SHORT;
        else if (phase_next == PH_Q_LEN || phase_next == PH_Q_LABEL ||
                 phase_next == PH_Q_PTR || phase_next == PH_Q_TAIL)
            end_kind = (a_next != 16'd0) ? K_TRUNC : K_DONE;
        else if (phase_next == PH_TRAIL)
            end_kind = K_DONE;
        else
            end_kind = K_TRUNC;
        fin.result_kind = end_kind;
        fin.final_result = 1'b1;

        if (eom)
        begin
            phase_next = PH_HEADER;
            hp_next = '0;
            q_next = '0;
            a_next = '0;
            skip_next = '0;
            fp_next = '0;
            kind_next = '0;
            ttl_next = '0;
            len_next = '0;
            code_next = '0;
            ap_next = '0;
        end
    end

    always_comb
    begin
        push = '0;
        if (accept)
        begin
            if (first_v)
            begin
                push.res0 = first;
                push.res1 = fin;
                push.cnt = eom ? 2'd2 : 2'd1;
            end
            else
            begin
                push.res0 = fin;
                push.cnt = eom ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hp_reg <= '0;
            q_reg <= '0;
            a_reg <= '0;
            skip_reg <= '0;
            fp_reg <= '0;
            kind_reg <= '0;
            ttl_reg <= '0;
            len_reg <= '0;
            code_reg <= '0;
            ap_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hp_reg <= hp_next;
            q_reg <= q_next;
            a_reg <= a_next;
            skip_reg <= skip_next;
            fp_reg <= fp_next;
            kind_reg <= kind_next;
            ttl_reg <= ttl_next;
            len_reg <= len_next;
            code_reg <= code_next;
            ap_reg <= ap_next;
        end
    end

    a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eom |=> phase_reg == PH_HEADER && hp_reg == 4'd0)
        else $error("parser did not restart after end of message");

    a_two_needs_eom: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> eom && push.res1.final_result)
        else $error("second result word without end of message");

    a_hp_range: assert property (@(posedge clk) disable iff (!rst_n)
        hp_reg <= HDR_LAST)
        else $error("header position out of range");

endmodule

// File: rtl/core/drsp_result_fifo.sv
// drsp_result_fifo: small result queue, up to two pushes and one pop per cycle
// depends on drsp_pkg; decouples the parser from output stalls

module drsp_result_fifo
    import drsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  space,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    res_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] rp_reg, wp_reg;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             pop;

    assign out_valid = (cnt_reg != '0);
    assign pop = out_valid && out_ready;
    assign space = (cnt_reg <= (PTR_W + 1)'(FIFO_DEPTH - 2));
    assign out_res = mem[rp_reg];
    assign cnt_next = cnt_reg + {{(PTR_W - 1){1'b0}}, push.cnt} - {{PTR_W{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem[wp_reg] <= push.res0;
        if (push.cnt == 2'd2)
            mem[wp_reg + PTR_W'(1)] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg <= '0;
            wp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (pop)
                rp_reg <= rp_reg + PTR_W'(1);
            wp_reg <= wp_reg + PTR_W'(push.cnt);
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PTR_W + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        !space |-> push.cnt == 2'd0)
        else $error("push into queue without room");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg == rp_reg + PTR_W'(cnt_reg))
        else $error("queue pointers and count disagree");

endmodule

// File: rtl/core/dns_response_stream_parser.sv
// a result word is queued as its byte is accepted and offered from the queue head
// throughput: one byte per cycle while results are taken; a final byte that also
//   completes a record or carries an address byte yields two words
// s_tready follows free room in a four-word result queue (at least two words free)
// reset: rst_n clears the parse state and empties the result queue

module dns_response_stream_parser
    import drsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // response code, answer_total, record_kind,
                                    // time_to_live, rdata_length, data_kind,
                                    // address_byte, address_index, zero fill
    output logic [2:0]   m_tuser,   // result_kind
    output logic         m_tlast    // final_result
);

    logic  accept;
    push_t push;
    res_t  res;

    assign accept = s_tvalid && s_tready;

    drsp_parser_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (s_tdata),
        .eom     (s_tlast),
        .push    (push)
    );

    drsp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'd0, res.address_index, res.address_byte, res.data_kind,
                      res.rdata_length, res.time_to_live, res.record_kind,
                      res.answer_total, res.resp_code};
    assign m_tuser = res.result_kind;
    assign m_tlast = res.final_result;

endmodule

// File: verif/drsp_checker.sv
// drsp_checker: watches both stream channels of the dns response parser,
// predicts every result word from the accepted message bytes and compares them
// depends on drsp_pkg for the phase, result and data kind types

module drsp_checker
    import drsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           mismatch_count,
    output int           results_pending
);

    res_t        expected_results[$];

    phase_t      phase;
    logic [3:0]  hdr_pos;
    logic [15:0] questions_left;
    logic [15:0] answers_left;
    logic [15:0] skip_cnt;
    logic [3:0]  fld_pos;
    logic [15:0] rr_type;
    logic [31:0] rr_ttl;
    logic [15:0] rr_len;
    logic [3:0]  rcode;
    logic [4:0]  addr_pos;

    function automatic res_t blank_result(input kind_t kind);
        res_t r;
        r = '0;
        r.result_kind = kind;
        return r;
    endfunction

    function automatic dkind_t rdata_class();
        if (rr_type == TYPE_A && rr_len == LEN_A)
            return DK_IPV4;
        if (rr_type == TYPE_AAAA && rr_len == LEN_AAAA)
            return DK_IPV6;
        if (rr_type == TYPE_CNAME)
            return DK_CNAME;
        return DK_NONE;
    endfunction

    function automatic string describe(input res_t r);
        return $sformatf({"kind %0d rcode %0d answers %0d type %0d ttl %0d len %0d",
                          " dkind %0d addr %0h idx %0d last %0b"},
                         r.result_kind, r.resp_code, r.answer_total, r.record_kind,
                         r.time_to_live, r.rdata_length, r.data_kind, r.address_byte,
                         r.address_index, r.final_result);
    endfunction

    task automatic expect_word(input res_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic clear_parse();
        phase = PH_HEADER;
        hdr_pos = '0;
        questions_left = '0;
        answers_left = '0;
        skip_cnt = '0;
        fld_pos = '0;
        rr_type = '0;
        rr_ttl = '0;
        rr_len = '0;
        rcode = '0;
        addr_pos = '0;
    endtask

    task automatic questions_finished();
        if (answers_left != 0)
            phase = PH_A_LEN;
        else
            phase = PH_TRAIL;
    endtask

    task automatic answer_finished();
        answers_left = answers_left - 16'd1;
        if (answers_left != 0)
            phase = PH_A_LEN;
        else
            phase = PH_TRAIL;
    endtask

    // label length byte: zero ends the name, top bits set is a pointer
    task automatic name_byte(input logic [7:0] b, input phase_t label_ph,
                             input phase_t ptr_ph, input phase_t done_ph);
        if (b == 8'h00)
        begin
            phase = done_ph;
            fld_pos = '0;
        end
        else if ((b & PTR_MASK) == PTR_MASK)
            phase = ptr_ph;
        else
        begin
            skip_cnt = {8'h00, b};
            phase = label_ph;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eom);
        res_t  r;
        kind_t closing;
        case (phase)
            PH_HEADER:
            begin
                case (hdr_pos)
                    4'd3: rcode = 4'(b & RCODE_MASK);
                    4'd4: questions_left = {b, 8'h00};
                    4'd5: questions_left[7:0] = b;
                    4'd6: answers_left = {b, 8'h00};
                    4'd7:
                    begin
                        answers_left[7:0] = b;
                        if (!eom)
                        begin
                            r = blank_result(K_HEADER);
                            r.resp_code = rcode;
                            r.answer_total = answers_left;
                            expect_word(r);
                        end
                    end
                    default: ;
                endcase
                if (hdr_pos >= HDR_LAST)
                begin
                    if (questions_left != 0)
                        phase = PH_Q_LEN;
                    else
                        questions_finished();
                end
                else
                    hdr_pos = hdr_pos + 4'd1;
            end
            PH_Q_LEN: name_byte(b, PH_Q_LABEL, PH_Q_PTR, PH_Q_TAIL);
            PH_Q_LABEL:
            begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0)
                    phase = PH_Q_LEN;
            end
            PH_Q_PTR:
            begin
                phase = PH_Q_TAIL;
                fld_pos = '0;
            end
            PH_Q_TAIL:
            begin
                if (fld_pos >= 4'd3)
                begin
                    questions_left = questions_left - 16'd1;
                    if (questions_left != 0)
                        phase = PH_Q_LEN;
                    else
                        questions_finished();
                end
                else
                    fld_pos = fld_pos + 4'd1;
            end
            PH_A_LEN: name_byte(b, PH_A_LABEL, PH_A_PTR, PH_A_FIXED);
            PH_A_LABEL:
            begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0)
                    phase = PH_A_LEN;
            end
            PH_A_PTR:
            begin
                phase = PH_A_FIXED;
                fld_pos = '0;
            end
            PH_A_FIXED:
            begin
                case (fld_pos)
                    4'd0: rr_type = {b, 8'h00};
                    4'd1: rr_type[7:0] = b;
                    4'd4: rr_ttl = {24'h0, b};
                    4'd5, 4'd6, 4'd7: rr_ttl = {rr_ttl[23:0], b};
                    4'd8: rr_len = {b, 8'h00};
                    4'd9: rr_len[7:0] = b;
                    default: ;
                endcase
                if (fld_pos >= 4'd9)
                begin
                    r = blank_result(K_RECORD);
                    r.record_kind = rr_type;
                    r.time_to_live = rr_ttl;
                    r.rdata_length = rr_len;
                    r.data_kind = rdata_class();
                    expect_word(r);
                    if (r.data_kind == DK_IPV4 || r.data_kind == DK_IPV6)
                    begin
                        phase = PH_A_ADDR;
                        addr_pos = '0;
                    end
                    else if (rr_len != 0)
                    begin
                        phase = PH_A_SKIP;
                        skip_cnt = rr_len;
                    end
                    else
                        answer_finished();
                end
                else
                    fld_pos = fld_pos + 4'd1;
            end
            PH_A_ADDR:
            begin
                r = blank_result(K_ADDR);
                if (rr_len == LEN_A)
                    r.data_kind = DK_IPV4;
                else
                    r.data_kind = DK_IPV6;
                r.address_byte = b;
                r.address_index = addr_pos[3:0];
                expect_word(r);
                addr_pos = addr_pos + 5'd1;
                if ({11'h0, addr_pos} >= rr_len)
                    answer_finished();
            end
            PH_A_SKIP:
            begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 0)
                    answer_finished();
            end
            default: ;
        endcase

        if (eom)
        begin
            if (phase == PH_HEADER)
                closing = K_SHORT;
            else if (phase >= PH_Q_LEN && phase <= PH_Q_TAIL)
                closing = (answers_left != 0) ? K_TRUNC : K_DONE;
            else if (phase >= PH_A_LEN && phase <= PH_A_SKIP)
                closing = K_TRUNC;
            else
                closing = K_DONE;
            r = blank_result(closing);
            r.final_result = 1'b1;
            expect_word(r);
            clear_parse();
        end
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            clear_parse();
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '0;
                got.result_kind = kind_t'(m_tuser);
                got.resp_code = m_tdata[3:0];
                got.answer_total = m_tdata[19:4];
                got.record_kind = m_tdata[35:20];
                got.time_to_live = m_tdata[67:36];
                got.rdata_length = m_tdata[83:68];
                got.data_kind = dkind_t'(m_tdata[85:84]);
                got.address_byte = m_tdata[93:86];
                got.address_index = m_tdata[97:94];
                got.final_result = m_tlast;
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected word: %s", describe(got));
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("word mismatch, expected: %s", describe(want));
                            $display("                 actual: %s", describe(got));
                        end
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
        end
        results_pending = expected_results.size();
    end

endmodule

// File: verif/tb.sv
// tb: drives dns response messages into the stream parser with random idle
// gaps and stalls on both sides; verdict comes from drsp_checker
// depends on drsp_pkg, dns_response_stream_parser and drsp_checker

module tb;
    import drsp_pkg::*;

    localparam int RANDOM_BYTES = 1850;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam int NAME_ANY = 0;
    localparam int NAME_PTR = 1;
    localparam int NAME_LABELS = 2;
    localparam int NAME_LABELS_PTR = 3;
    localparam int NAME_WIDE = 4;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int           mismatch_count;
    int           results_pending;
    int           cycle_count = 0;
    int           sent_bytes = 0;
    bit           burst = 1'b0;
    logic [7:0]   msg[$];

    always #5 clk = ~clk;

    dns_response_stream_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    drsp_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        gap = burst ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        msg.insert(msg.size(), b);
    endtask

    task automatic put_rand(input int n);
        repeat (n) put_byte(8'($urandom));
    endtask

    task automatic put_word(input logic [15:0] w);
        put_byte(w[15:8]);
        put_byte(w[7:0]);
    endtask

    task automatic put_pointer();
        put_byte(PTR_MASK | 8'($urandom_range(0, 63)));
        put_rand(1);
    endtask

    task automatic add_name(input int form);
        int shape;
        int labels;
        int len;
        int r;
        shape = form;
        if (shape == NAME_ANY)
        begin
            r = $urandom_range(0, 19);
            if (r < 6)
                shape = NAME_PTR;
            else if (r < 14)
                shape = NAME_LABELS;
            else if (r < 19)
                shape = NAME_LABELS_PTR;
            else
                shape = NAME_WIDE;
        end
        case (shape)
            NAME_PTR: put_pointer();
            NAME_WIDE:
            begin
                len = $urandom_range(64, 191);
                put_byte(8'(len));
                put_rand(len);
                put_byte(8'h00);
            end
            default:
            begin
                labels = $urandom_range((shape == NAME_LABELS) ? 0 : 1, 3);
                repeat (labels)
                begin
                    len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 12);
                    put_byte(8'(len));
                    put_rand(len);
                end
                if (shape == NAME_LABELS)
                    put_byte(8'h00);
                else
                    put_pointer();
            end
        endcase
    endtask

    task automatic add_header(input logic [3:0] code, input logic [15:0] qd,
                              input logic [15:0] an);
        put_rand(3);
        put_byte({4'($urandom), code});
        put_word(qd);
        put_word(an);
        put_rand(4);
    endtask

    task automatic add_question(input int form);
        add_name(form);
        put_rand(4);
    endtask

    task automatic add_answer(input int form, input logic [15:0] rtype,
                              input logic [15:0] rlen, input logic [31:0] ttl);
        add_name(form);
        put_word(rtype);
        put_rand(2);
        put_word(ttl[31:16]);
        put_word(ttl[15:0]);
        put_word(rlen);
        put_rand(rlen);
    endtask

    task automatic random_answer();
        logic [15:0] rtype;
        logic [15:0] rlen;
        logic [31:0] ttl;
        int          c;
        c = $urandom_range(0, 11);
        case (c)
            0, 1, 2:
            begin
                rtype = TYPE_A;
                rlen = LEN_A;
            end
            3:
            begin
                rtype = TYPE_A;
                rlen = 16'($urandom_range(0, 8));
            end
            4, 5:
            begin
                rtype = TYPE_AAAA;
                rlen = LEN_AAAA;
            end
            6:
            begin
                rtype = TYPE_AAAA;
                rlen = 16'($urandom_range(0, 20));
            end
            7:
            begin
                rtype = TYPE_CNAME;
                rlen = 16'($urandom_range(0, 12));
            end
            8:
            begin
                rtype = 16'($urandom);
                rlen = 16'($urandom_range(0, 12));
            end
            9:
            begin
                rtype = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                rlen = 16'($urandom_range(0, 6));
            end
            10:
            begin
                rtype = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 1) ? 1 : 28)};
                rlen = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(100, 300))
                                                   : 16'($urandom_range(4, 16));
            end
            default:
            begin
                rtype = 16'($urandom_range(0, 40));
                rlen = 16'($urandom_range(0, 16));
            end
        endcase
        c = $urandom_range(0, 9);
        if (c == 0)
            ttl = 32'h0;
        else if (c == 1)
            ttl = 32'hFFFF_FFFF;
        else
            ttl = $urandom;
        add_answer(NAME_ANY, rtype, rlen, ttl);
    endtask

    // sends the first n bytes of the built message, all of it when n is zero
    task automatic send_message(input int n);
        int count;
        count = (n <= 0 || n > msg.size()) ? msg.size() : n;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
            push_byte(msg[i], i == count - 1);
        sent_bytes = sent_bytes + count;
        msg.delete();
    endtask

    function automatic logic [15:0] pick_count(input int top);
        if ($urandom_range(0, 99) < 8)
            return 16'($urandom);
        return 16'($urandom_range(0, top));
    endfunction

    task automatic random_message();
        logic [15:0] qd;
        logic [15:0] an;
        int          e;
        int          cut;
        if ($urandom_range(0, 19) == 0)
        begin
            put_rand($urandom_range(1, 40));
            send_message(0);
            return;
        end
        qd = pick_count(2);
        an = pick_count(3);
        add_header(4'($urandom), qd, an);
        for (int k = 0; k < qd && k < 3; k++)
            add_question(NAME_ANY);
        for (int k = 0; k < an && k < 4; k++)
            random_answer();
        if ($urandom_range(0, 4) == 0)
            put_rand($urandom_range(1, 4));
        e = $urandom_range(0, 99);
        if (e < 70)
            cut = 0;
        else if (e < 85)
            cut = $urandom_range(HEADER_BYTES, msg.size());
        else if (e < 95)
            cut = $urandom_range(1, HEADER_BYTES - 1);
        else
            cut = $urandom_range(1, msg.size());
        send_message(cut);
    endtask

    task automatic run_directed();
        // one byte, then a message ending right on the answer count byte
        put_byte(8'hFF);
        send_message(0);
        put_rand(8);
        send_message(0);
        // header only, extreme response code and answer counts
        add_header(4'hF, 16'h0000, 16'h0000);
        send_message(0);
        add_header(4'h0, 16'h0000, 16'hFFFF);
        send_message(0);
        // questions only, then questions with answers still owed
        add_header(4'h5, 16'h0001, 16'h0000);
        add_question(NAME_LABELS);
        send_message(0);
        add_header(4'h2, 16'h0002, 16'h0001);
        add_question(NAME_PTR);
        send_message(0);
        // every data kind, pointer after labels, wide label, trailing bytes
        add_header(4'h0, 16'h0000, 16'h0001);
        add_answer(NAME_PTR, TYPE_A, LEN_A, 32'hFFFF_FFFF);
        send_message(0);
        add_header(4'h3, 16'h0001, 16'h0004);
        add_question(NAME_LABELS_PTR);
        add_answer(NAME_LABELS, TYPE_AAAA, LEN_AAAA, 32'h0);
        add_answer(NAME_LABELS_PTR, TYPE_CNAME, 16'd6, 32'h1234_5678);
        add_answer(NAME_PTR, 16'hFFFF, 16'd0, 32'h8000_0001);
        add_answer(NAME_WIDE, TYPE_A, 16'd3, 32'h7FFF_FFFF);
        put_rand(3);
        send_message(0);
        // ends inside skipped data and inside an address
        add_header(4'h1, 16'h0000, 16'h0001);
        add_answer(NAME_PTR, 16'd16, 16'd9, 32'h0000_0E10);
        send_message(msg.size() - 3);
        add_header(4'h0, 16'h0000, 16'h0002);
        add_answer(NAME_PTR, TYPE_AAAA, LEN_AAAA, 32'h0000_003C);
        send_message(msg.size() - 5);
    endtask

    initial
    begin
        int run;
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (sent_bytes < RANDOM_BYTES)
            random_message();
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/drsp_pkg.sv
rtl/core/drsp_parser_core.sv
rtl/core/drsp_result_fifo.sv
rtl/core/dns_response_stream_parser.sv
verif/drsp_checker.sv
verif/tb.sv
